// ===== hw/rtl/ddrs_pkg.sv =====
package ddrs_pkg;

	// Field widths
	localparam int CMD_W     = 3;
	localparam int SPEED_W   = 16;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 32;
	localparam int RPM_W     = 22;
	localparam int DIST_W    = 48;
	localparam int SUM_W     = COUNT_W + 1;
	localparam int CORR_W    = 42;
	localparam int SAT_W     = 48;

	// Configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	localparam int MAX_SPEED_W = 15;
	localparam int GAIN_W      = 24;
	localparam int ACCEL_W     = 24;
	localparam int SYNC_W      = 16;
	localparam int CM_W        = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SPEED    = 3'd0,
		CFG_GAIN         = 3'd1,
		CFG_MIN_INTERVAL = 3'd2,
		CFG_ACCEL        = 3'd3,
		CFG_SYNC_GAIN    = 3'd4,
		CFG_CM_PER_TICK  = 3'd5
	} cfg_idx_t;

	localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST    = 15'd7680;
	localparam logic [GAIN_W-1:0]      GAIN_RST         = 24'd196608;
	localparam logic [TIME_W-1:0]      MIN_INTERVAL_RST = 32'd20000;
	localparam logic [ACCEL_W-1:0]     ACCEL_RST        = 24'd32768;
	localparam logic [SYNC_W-1:0]      SYNC_RST         = 16'd0;
	localparam logic [CM_W-1:0]        CM_RST           = 24'd335544;

	// Commands
	typedef enum logic [CMD_W-1:0] {
		CMD_START_STRAIGHT = 3'd0,
		CMD_START_SPIN     = 3'd1,
		CMD_STOP           = 3'd2,
		CMD_TICK           = 3'd3,
		CMD_CLEAR_DIST     = 3'd4
	} cmd_t;

	// Result queue depth, counting items still in the pipeline
	localparam int OUTQ_DEPTH_DEF = 8;

	localparam logic signed [SAT_W-1:0] RPM_MAX_X = 48'sd2097151;
	localparam logic signed [SAT_W-1:0] RPM_MIN_X = -48'sd2097152;

	// Per-item control flags carried down the pipeline
	typedef struct packed {
		logic valid;
		logic start;
		logic zero_cmd;
		logic stop;
		logic clr_odo;
		logic due;
		logic do_odo;
		logic spin;
		logic restart;
		logic halt;
		logic moving;
	} ddrs_flags_t;

	// Data leaving the decision stage
	typedef struct packed {
		logic [SPEED_W-1:0] spd;
		logic [TIME_W-1:0]  elapsed;
		logic [SUM_W-1:0]   mag;
		logic [SUM_W-1:0]   err;
	} ddrs_dec_t;

	// One result item
	typedef struct packed {
		logic [RPM_W-1:0]  left_rpm;
		logic [RPM_W-1:0]  right_rpm;
		logic              setpoints_valid;
		logic              restart_wheels;
		logic              halt_wheels;
		logic              moving;
		logic [DIST_W-1:0] distance;
	} ddrs_result_t;

	// Saturate a wide signed value to the RPM range
	function automatic logic [RPM_W-1:0] sat_rpm(input logic signed [SAT_W-1:0] x);
		logic [RPM_W-1:0] r;
		if (x > RPM_MAX_X)
			r = RPM_MAX_X[RPM_W-1:0];
		else if (x < RPM_MIN_X)
			r = RPM_MIN_X[RPM_W-1:0];
		else
			r = x[RPM_W-1:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/ddrs_if.sv =====
interface ddrs_item_if import ddrs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [SPEED_W-1:0] speed;
	logic [TIME_W-1:0]         time_us;
	logic signed [COUNT_W-1:0] left_count;
	logic signed [COUNT_W-1:0] right_count;

	modport source(output valid, cmd, speed, time_us, left_count, right_count, input ready);
	modport sink(input valid, cmd, speed, time_us, left_count, right_count, output ready);
endinterface

interface ddrs_result_if import ddrs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RPM_W-1:0] left_rpm;
	logic signed [RPM_W-1:0] right_rpm;
	logic                    setpoints_valid;
	logic                    restart_wheels;
	logic                    halt_wheels;
	logic                    moving;
	logic [DIST_W-1:0]       distance;

	modport source(output valid, left_rpm, right_rpm, setpoints_valid, restart_wheels,
		halt_wheels, moving, distance, input ready);
	modport sink(input valid, left_rpm, right_rpm, setpoints_valid, restart_wheels,
		halt_wheels, moving, distance, output ready);
endinterface

// ===== hw/rtl/ddrs_ctrl.sv =====
module ddrs_ctrl import ddrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [CMD_W-1:0]       cmd,
	input  logic [SPEED_W-1:0]     speed,
	input  logic [TIME_W-1:0]      time_us,
	input  logic [COUNT_W-1:0]     left_count,
	input  logic [COUNT_W-1:0]     right_count,
	input  logic [MAX_SPEED_W-1:0] max_speed,
	input  logic [TIME_W-1:0]      min_interval,
	output ddrs_flags_t            flags_s2,
	output ddrs_dec_t              dec_s2
);

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_STRAIGHT = 2'd1,
		MODE_SPIN     = 2'd2
	} mode_t;

	logic               v_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [SPEED_W-1:0] speed_s1;
	logic [TIME_W-1:0]  time_s1;
	logic [COUNT_W-1:0] lc_s1;
	logic [COUNT_W-1:0] rc_s1;

	mode_t              mode_q;
	mode_t              mode_d;
	logic [TIME_W-1:0]  prev_time_q;
	logic [SUM_W-1:0]   prev_sum_q;

	logic               is_start;
	logic               is_stop;
	logic               idle;
	logic               due;
	logic [TIME_W-1:0]  elapsed;
	logic [SUM_W-1:0]   sum_now;
	logic [SUM_W:0]     diff;
	logic [SUM_W-1:0]   mag;
	logic [SUM_W-1:0]   err;
	logic signed [SPEED_W-1:0] lim;
	logic signed [SPEED_W-1:0] nlim;
	logic signed [SPEED_W-1:0] spd_c;
	ddrs_flags_t        flags_d;

	// Capture accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			speed_s1 <= speed;
			time_s1  <= time_us;
			lc_s1    <= left_count;
			rc_s1    <= right_count;
		end
	end

	// Decode the command against the current mode
	always_comb begin
		is_start = (cmd_s1 == CMD_START_STRAIGHT) || (cmd_s1 == CMD_START_SPIN);
		is_stop  = (cmd_s1 == CMD_STOP);
		idle     = (mode_q == MODE_IDLE);
		elapsed  = time_s1 - prev_time_q;
		due      = (cmd_s1 == CMD_TICK) && !idle && (elapsed >= min_interval);

		mode_d = mode_q;
		if (is_start)
			mode_d = (cmd_s1 == CMD_START_STRAIGHT) ? MODE_STRAIGHT : MODE_SPIN;
		else if (is_stop)
			mode_d = MODE_IDLE;
	end

	// Odometry difference and sync error
	always_comb begin
		sum_now = {lc_s1[COUNT_W-1], lc_s1} + {rc_s1[COUNT_W-1], rc_s1};
		diff    = {sum_now[SUM_W-1], sum_now} - {prev_sum_q[SUM_W-1], prev_sum_q};
		mag     = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
		if (mode_q == MODE_SPIN)
			err = sum_now;
		else
			err = {lc_s1[COUNT_W-1], lc_s1} - {rc_s1[COUNT_W-1], rc_s1};
	end

	// Clamp the requested speed
	always_comb begin
		lim  = $signed({1'b0, max_speed});
		nlim = -lim;
		if ($signed(speed_s1) > lim)
			spd_c = lim;
		else if ($signed(speed_s1) < nlim)
			spd_c = nlim;
		else
			spd_c = $signed(speed_s1);
	end

	always_comb begin
		flags_d.valid    = v_s1;
		flags_d.start    = is_start;
		flags_d.zero_cmd = is_stop || (is_start && idle);
		flags_d.stop     = is_stop;
		flags_d.clr_odo  = (cmd_s1 == CMD_CLEAR_DIST);
		flags_d.due      = due;
		flags_d.do_odo   = due && (mode_q == MODE_STRAIGHT);
		flags_d.spin     = (mode_q == MODE_SPIN);
		flags_d.restart  = is_start && idle;
		flags_d.halt     = is_stop;
		flags_d.moving   = (mode_d != MODE_IDLE);
	end

	// Hold mode, time base and count baseline; advance the decision stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			prev_time_q <= '0;
			prev_sum_q  <= '0;
			flags_s2    <= '0;
		end else begin
			flags_s2 <= flags_d;
			if (v_s1) begin
				mode_q <= mode_d;
				if (is_start && idle) begin
					prev_time_q <= time_s1;
					prev_sum_q  <= '0;
				end else if (due) begin
					prev_time_q <= time_s1;
					prev_sum_q  <= sum_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		dec_s2.spd     <= spd_c;
		dec_s2.elapsed <= elapsed;
		dec_s2.mag     <= mag;
		dec_s2.err     <= err;
	end

endmodule

// ===== hw/rtl/ddrs_ramp.sv =====
module ddrs_ramp import ddrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ddrs_flags_t        flags_s2,
	input  ddrs_dec_t          dec_s2,
	input  logic [GAIN_W-1:0]  gain,
	input  logic [ACCEL_W-1:0] accel,
	input  logic [SYNC_W-1:0]  sync_gain,
	input  logic [CM_W-1:0]    cm_per_tick,
	output ddrs_flags_t        flags_s4,
	output logic [CORR_W-1:0]  corr_s4,
	output logic [RPM_W-1:0]   cmd_rpm,
	output logic [DIST_W-1:0]  distance
);

	localparam int TPROD_W = SPEED_W + GAIN_W + 1;
	localparam int APROD_W = ACCEL_W + TIME_W;
	localparam int OPROD_W = SUM_W + CM_W;
	localparam int CPROD_W = CORR_W + 8;

	ddrs_flags_t                 flags_s3;
	logic signed [TPROD_W-1:0]   tprod_s3;
	logic [APROD_W-1:0]          aprod_s3;
	logic                        snap_s3;
	logic [OPROD_W-2:0]          oadd_s3;
	logic signed [CPROD_W-1:0]   cprod_s3;

	logic signed [TPROD_W-1:0]   tprod;
	logic [APROD_W-1:0]          aprod;
	logic [OPROD_W-1:0]          oprod;
	logic signed [CPROD_W-1:0]   cprod;

	logic [RPM_W-1:0]            target_q;
	logic [DIST_W-1:0]           odo_q;

	logic signed [TPROD_W-1:0]   t_rnd;
	logic [RPM_W-1:0]            target_new;
	logic [APROD_W-17:0]         md;
	logic [RPM_W+1:0]            m;
	logic signed [RPM_W:0]       tdiff;
	logic signed [RPM_W+2:0]     d25;
	logic signed [RPM_W+2:0]     m25;
	logic signed [RPM_W+2:0]     step;
	logic signed [RPM_W+2:0]     c_sum;
	logic [RPM_W-1:0]            cmd_new;
	logic [DIST_W+8:0]           o_sum;
	logic [DIST_W-1:0]           odo_new;
	logic signed [CPROD_W-1:0]   c_rnd;

	// Multiply stage
	always_comb begin
		tprod = $signed(dec_s2.spd) * $signed({1'b0, gain});
		aprod = accel * dec_s2.elapsed;
		oprod = dec_s2.mag * cm_per_tick;
		cprod = $signed(dec_s2.err) * $signed({1'b0, sync_gain});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flags_s3 <= '0;
		else
			flags_s3 <= flags_s2;
	end

	always_ff @(posedge clk) begin
		tprod_s3 <= tprod;
		aprod_s3 <= aprod;
		snap_s3  <= (accel == '0) || (dec_s2.elapsed == '0);
		oadd_s3  <= oprod[OPROD_W-1:1];
		cprod_s3 <= cprod;
	end

	// New target: shift toward zero and saturate
	always_comb begin
		t_rnd      = tprod_s3 + (tprod_s3[TPROD_W-1] ? TPROD_W'(65535) : TPROD_W'(0));
		target_new = sat_rpm(SAT_W'($signed(t_rnd[TPROD_W-1:16])));
	end

	// Slew the commanded value toward the target
	always_comb begin
		md = aprod_s3[APROD_W-1:16];
		if ((|md[APROD_W-17:24]) || (md[23] && (|md[22:0])))
			m = (RPM_W+2)'(24'h800000);
		else
			m = md[RPM_W+1:0];
		tdiff = $signed({target_q[RPM_W-1], target_q}) - $signed({cmd_rpm[RPM_W-1], cmd_rpm});
		d25   = (RPM_W+3)'(tdiff);
		m25   = $signed({1'b0, m});
		if (d25 > m25)
			step = m25;
		else if (d25 < -m25)
			step = -m25;
		else
			step = d25;
		c_sum   = $signed({{3{cmd_rpm[RPM_W-1]}}, cmd_rpm}) + step;
		cmd_new = sat_rpm(SAT_W'(c_sum));
	end

	// Saturating odometer add
	always_comb begin
		o_sum   = {9'd0, odo_q} + {1'b0, oadd_s3};
		odo_new = (|o_sum[DIST_W+8:DIST_W]) ? '1 : o_sum[DIST_W-1:0];
	end

	// Sync correction shifted toward zero
	always_comb begin
		c_rnd = cprod_s3 + (cprod_s3[CPROD_W-1] ? CPROD_W'(255) : CPROD_W'(0));
	end

	// Hold target, commanded value and odometer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			cmd_rpm  <= '0;
			odo_q    <= '0;
			flags_s4 <= '0;
		end else begin
			flags_s4 <= flags_s3;
			if (flags_s3.valid) begin
				if (flags_s3.stop) begin
					target_q <= '0;
					cmd_rpm  <= '0;
				end else if (flags_s3.start) begin
					target_q <= target_new;
					if (flags_s3.zero_cmd)
						cmd_rpm <= '0;
				end else if (flags_s3.due) begin
					cmd_rpm <= snap_s3 ? target_q : cmd_new;
				end
				if (flags_s3.clr_odo)
					odo_q <= '0;
				else if (flags_s3.do_odo)
					odo_q <= odo_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		corr_s4 <= c_rnd[CPROD_W-1:8];
	end

	assign distance = odo_q;

endmodule

// ===== hw/rtl/ddrs_outq.sv =====
module ddrs_outq import ddrs_pkg::*; #(
	parameter int DEPTH = OUTQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ddrs_flags_t       flags_s4,
	input  logic [CORR_W-1:0] corr_s4,
	input  logic [RPM_W-1:0]  cmd_rpm,
	input  logic [DIST_W-1:0] distance,
	ddrs_result_if.source     results
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ddrs_result_t       mem [DEPTH];
	ddrs_result_t       res_d;
	ddrs_result_t       head;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	logic signed [SAT_W-1:0] c_x;
	logic signed [SAT_W-1:0] k_x;

	// Final wheel setpoints
	always_comb begin
		c_x = SAT_W'($signed(cmd_rpm));
		k_x = SAT_W'($signed(corr_s4));
		res_d.left_rpm  = '0;
		res_d.right_rpm = '0;
		if (flags_s4.due) begin
			res_d.left_rpm = sat_rpm(c_x - k_x);
			if (flags_s4.spin)
				res_d.right_rpm = sat_rpm(-c_x - k_x);
			else
				res_d.right_rpm = sat_rpm(c_x + k_x);
		end
		res_d.setpoints_valid = flags_s4.due;
		res_d.restart_wheels  = flags_s4.restart;
		res_d.halt_wheels     = flags_s4.halt;
		res_d.moving          = flags_s4.moving;
		res_d.distance        = distance;
	end

	assign push = flags_s4.valid;
	assign pop  = results.valid && results.ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= res_d;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head = mem[rd_ptr_q];

	assign results.valid           = (cnt_q != '0);
	assign results.left_rpm        = head.left_rpm;
	assign results.right_rpm       = head.right_rpm;
	assign results.setpoints_valid = head.setpoints_valid;
	assign results.restart_wheels  = head.restart_wheels;
	assign results.halt_wheels     = head.halt_wheels;
	assign results.moving          = head.moving;
	assign results.distance        = head.distance;

endmodule

// ===== hw/rtl/diff_drive_ramp_sync.sv =====
// Differential-drive setpoint generator with slew limiting and wheel sync.
// Items enter on the items channel (cmd, speed, time_us, encoder counts) and
// every item yields exactly one item on the results channel, in order.
// Registers are written through cfg_we / cfg_idx / cfg_data; the user must
// do so only while no item is in flight (the block does not enforce this).
// Path: an accepted item passes the input register, decision stage (mode,
// tick timing), multiplier stage, ramp and odometer update stage, then the
// result queue, from which its result is offered.
// Throughput: one item per cycle while items.ready is high; the mode/time
// decision, the ramp update and the odometer add each finish before the next item reaches them.
// Reset: mode idle, target and commanded RPM zero, baselines and odometer
// zero, registers at their defaults, result queue empty.
// Stall: the result queue holds OUTQ_DEPTH items including those still in
// the pipeline; items.ready drops only once that many results are owed, so
// the input keeps flowing while a finished result waits.
module diff_drive_ramp_sync import ddrs_pkg::*; #(
	parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	ddrs_item_if.sink            items,
	ddrs_result_if.source        results
);

	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	logic [MAX_SPEED_W-1:0] max_speed_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [TIME_W-1:0]      min_interval_q;
	logic [ACCEL_W-1:0]     accel_q;
	logic [SYNC_W-1:0]      sync_q;
	logic [CM_W-1:0]        cm_q;

	logic [CNT_W-1:0]       owed_q;
	logic                   accept;
	logic                   pop;

	ddrs_flags_t            flags_s2;
	ddrs_dec_t              dec_s2;
	ddrs_flags_t            flags_s4;
	logic [CORR_W-1:0]      corr_s4;
	logic [RPM_W-1:0]       cmd_rpm;
	logic [DIST_W-1:0]      distance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q    <= MAX_SPEED_RST;
			gain_q         <= GAIN_RST;
			min_interval_q <= MIN_INTERVAL_RST;
			accel_q        <= ACCEL_RST;
			sync_q         <= SYNC_RST;
			cm_q           <= CM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_SPEED:    max_speed_q    <= cfg_data[MAX_SPEED_W-1:0];
				CFG_GAIN:         gain_q         <= cfg_data[GAIN_W-1:0];
				CFG_MIN_INTERVAL: min_interval_q <= cfg_data[TIME_W-1:0];
				CFG_ACCEL:        accel_q        <= cfg_data[ACCEL_W-1:0];
				CFG_SYNC_GAIN:    sync_q         <= cfg_data[SYNC_W-1:0];
				CFG_CM_PER_TICK:  cm_q           <= cfg_data[CM_W-1:0];
				default: ;
			endcase
		end
	end

	// Count results owed: in the pipeline or waiting in the queue
	assign accept      = items.valid && items.ready;
	assign pop         = results.valid && results.ready;
	assign items.ready = (owed_q != CNT_W'(OUTQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			owed_q <= '0;
		else if (accept && !pop)
			owed_q <= owed_q + 1'b1;
		else if (pop && !accept)
			owed_q <= owed_q - 1'b1;
	end

	ddrs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (items.cmd),
		.speed        (items.speed),
		.time_us      (items.time_us),
		.left_count   (items.left_count),
		.right_count  (items.right_count),
		.max_speed    (max_speed_q),
		.min_interval (min_interval_q),
		.flags_s2     (flags_s2),
		.dec_s2       (dec_s2)
	);

	ddrs_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.flags_s2    (flags_s2),
		.dec_s2      (dec_s2),
		.gain        (gain_q),
		.accel       (accel_q),
		.sync_gain   (sync_q),
		.cm_per_tick (cm_q),
		.flags_s4    (flags_s4),
		.corr_s4     (corr_s4),
		.cmd_rpm     (cmd_rpm),
		.distance    (distance)
	);

	ddrs_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags_s4 (flags_s4),
		.corr_s4  (corr_s4),
		.cmd_rpm  (cmd_rpm),
		.distance (distance),
		.results  (results)
	);

endmodule
